>>> design/tlic_pkg.sv
package tlic_pkg;

    // Fixed field widths
    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 10;
    localparam int LINE_SHIFT = 6;
    localparam int LINE_W     = ADDR_W - LINE_SHIFT;
    localparam int CNT_W      = 64;
    localparam int MAX_SIZE   = 512;
    localparam int MAX_LINES  = 9;
    localparam int LCNT_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    // SRRIP ages
    localparam logic [1:0] RRPV_MAX    = 2'd3;
    localparam logic [1:0] RRPV_INSERT = 2'd2;

    // Default geometry
    localparam int L1_SETS_DEF  = 128;
    localparam int L1_ASSOC_DEF = 8;
    localparam int L2_SETS_DEF  = 1024;
    localparam int L2_ASSOC_DEF = 16;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] access_size;
    } access_t;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic              l1_hit;
        logic              l2_hit;
        logic              victim_valid;
        logic [LINE_W-1:0] victim_line;
        logic [CNT_W-1:0]  l1_miss_total;
        logic [CNT_W-1:0]  l2_miss_total;
        logic              last_line;
    } result_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic              last;
    } line_item_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOK,
        BK_L1WR,
        BK_L2WR,
        BK_BWR,
        BK_FRD,
        BK_FWR,
        BK_OUT
    } back_state_t;

endpackage

>>> design/tlic_ram.sv
module tlic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, hold when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/tlic_front.sv
module tlic_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlic_pkg::access_t    access,
    input  logic                 access_valid,
    output logic                 access_stall,
    output tlic_pkg::line_item_t item,
    output logic                 item_valid,
    input  logic                 item_full
);
    import tlic_pkg::*;

    logic              busy_reg, busy_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [LCNT_W-1:0] left_reg, left_next;

    logic [SIZE_W-1:0]   size_fix;
    logic [SIZE_W:0]     span;
    logic [LCNT_W-1:0]   count;

    // Clamp the size and count the lines it spans
    always_comb
    begin
        size_fix = access.access_size;
        if (size_fix == '0)
        begin
            size_fix = SIZE_W'(1);
        end
        else if (size_fix > SIZE_W'(MAX_SIZE))
        begin
            size_fix = SIZE_W'(MAX_SIZE);
        end
        span  = (SIZE_W+1)'(access.address[LINE_SHIFT-1:0]) + (SIZE_W+1)'(size_fix)
              - (SIZE_W+1)'(1);
        count = LCNT_W'(span >> LINE_SHIFT) + LCNT_W'(1);
        if (count > LCNT_W'(MAX_LINES))
        begin
            count = LCNT_W'(MAX_LINES);
        end
    end

    assign access_stall = busy_reg;
    assign item_valid   = busy_reg;
    assign item.line    = line_reg;
    assign item.last    = (left_reg == LCNT_W'(1));

    // Take an access, then emit one line per transfer into the queue
    always_comb
    begin
        busy_next = busy_reg;
        line_next = line_reg;
        left_next = left_reg;
        if (!busy_reg)
        begin
            if (access_valid)
            begin
                busy_next = 1'b1;
                line_next = access.address[ADDR_W-1:LINE_SHIFT];
                left_next = count;
            end
        end
        else if (!item_full)
        begin
            line_next = line_reg + LINE_W'(1);
            left_next = left_reg - LCNT_W'(1);
            if (left_reg == LCNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
        left_reg <= left_next;
    end

endmodule

>>> design/tlic_queue.sv
module tlic_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlic_pkg::line_item_t push_item,
    input  logic                 push_valid,
    output logic                 full,
    output tlic_pkg::line_item_t pop_item,
    output logic                 pop_valid,
    input  logic                 pop
);
    import tlic_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    line_item_t      mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full      = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_item  = mem_reg[rd_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_next  = do_push ? wr_reg + PW'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + PW'(1) : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

>>> design/tlic_back.sv
module tlic_back #(
    parameter int L1_SETS  = tlic_pkg::L1_SETS_DEF,
    parameter int L1_ASSOC = tlic_pkg::L1_ASSOC_DEF,
    parameter int L2_SETS  = tlic_pkg::L2_SETS_DEF,
    parameter int L2_ASSOC = tlic_pkg::L2_ASSOC_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlic_pkg::line_item_t pop_item,
    input  logic                 pop_valid,
    output logic                 pop,
    output tlic_pkg::result_t    result,
    output logic                 result_valid,
    input  logic                 result_stall
);
    import tlic_pkg::*;

    localparam int S1B = $clog2(L1_SETS);
    localparam int S2B = $clog2(L2_SETS);
    localparam int T1W = LINE_W - S1B;
    localparam int T2W = LINE_W - S2B;
    localparam int RW  = $clog2(L1_ASSOC);
    localparam int W1B = $clog2(L1_ASSOC);
    localparam int W2B = $clog2(L2_ASSOC);
    localparam int E1W = 1 + RW + T1W;
    localparam int E2W = 3 + T2W;
    localparam int R1W = L1_ASSOC * E1W;
    localparam int R2W = L2_ASSOC * E2W;
    localparam int CLR_N = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
    localparam int CW  = $clog2(CLR_N);

    back_state_t state_reg, state_next;

    logic [CW-1:0]     clr_reg, clr_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              last_reg, last_next;
    logic              l1h_reg, l1h_next;
    logic              l2h_reg, l2h_next;
    logic              vv_reg, vv_next;
    logic [LINE_W-1:0] vline_reg, vline_next;
    logic [W1B-1:0]    way1_reg, way1_next;
    logic [W2B-1:0]    pick2_reg, pick2_next;
    logic [1:0]        inc_reg, inc_next;
    logic [CNT_W-1:0]  l1cnt_reg, l1cnt_next;
    logic [CNT_W-1:0]  l2cnt_reg, l2cnt_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              re1, we1, re2, we2;
    logic [S1B-1:0]    raddr1, waddr1;
    logic [S2B-1:0]    raddr2, waddr2;
    logic [R1W-1:0]    wdata1, rd1;
    logic [R2W-1:0]    wdata2, rd2;
    logic              out_load;
    logic              clr_last;

    logic [S1B-1:0]    set1;
    logic [T1W-1:0]    tag1;
    logic [S2B-1:0]    set2;
    logic [T2W-1:0]    tag2;

    logic              hit1, hit2, inv_any;
    logic [W1B-1:0]    hitw1;
    logic [W2B-1:0]    hitw2, invw2, agew2;
    logic [1:0]        maxage;
    logic [T2W-1:0]    agetag;

    assign set1 = line_reg[S1B-1:0];
    assign tag1 = line_reg[LINE_W-1:S1B];
    assign set2 = line_reg[S2B-1:0];
    assign tag2 = line_reg[LINE_W-1:S2B];
    assign clr_last = (clr_reg == CW'(CLR_N - 1));

    tlic_ram #(.WIDTH(R1W), .DEPTH(L1_SETS)) u_l1_ram (
        .clk(clk), .we(we1), .waddr(waddr1), .wdata(wdata1),
        .re(re1), .raddr(raddr1), .rdata(rd1)
    );

    tlic_ram #(.WIDTH(R2W), .DEPTH(L2_SETS)) u_l2_ram (
        .clk(clk), .we(we2), .waddr(waddr2), .wdata(wdata2),
        .re(re2), .raddr(raddr2), .rdata(rd2)
    );

    // Move way w of an L1 set to most recent
    function automatic logic [R1W-1:0] l1_touch(input logic [R1W-1:0] row,
                                                input logic [W1B-1:0] w);
        logic [R1W-1:0] r;
        logic [RW:0]    old;
        r   = row;
        old = (RW+1)'(L1_ASSOC);
        for (int v = 0; v < L1_ASSOC; v++)
        begin
            if (W1B'(v) == w && row[v*E1W])
            begin
                old = {1'b0, row[v*E1W+1 +: RW]};
            end
        end
        for (int v = 0; v < L1_ASSOC; v++)
        begin
            if (W1B'(v) == w)
            begin
                r[v*E1W+1 +: RW] = '0;
            end
            else if (row[v*E1W] && ({1'b0, row[v*E1W+1 +: RW]} < old))
            begin
                r[v*E1W+1 +: RW] = row[v*E1W+1 +: RW] + RW'(1);
            end
        end
        return r;
    endfunction

    // Drop a matching line from an L1 set and close the rank gap
    function automatic logic [R1W-1:0] l1_inval(input logic [R1W-1:0] row,
                                                input logic [T1W-1:0] t);
        logic [R1W-1:0] r;
        logic           found;
        logic [RW-1:0]  rk;
        r     = row;
        found = 1'b0;
        rk    = '0;
        for (int v = 0; v < L1_ASSOC; v++)
        begin
            if (!found && row[v*E1W] && row[v*E1W+1+RW +: T1W] == t)
            begin
                found    = 1'b1;
                rk       = row[v*E1W+1 +: RW];
                r[v*E1W] = 1'b0;
            end
        end
        if (found)
        begin
            for (int v = 0; v < L1_ASSOC; v++)
            begin
                if (r[v*E1W] && row[v*E1W+1 +: RW] > rk)
                begin
                    r[v*E1W+1 +: RW] = row[v*E1W+1 +: RW] - RW'(1);
                end
            end
        end
        return r;
    endfunction

    // Fill an L1 set: first invalid way, else the least recent
    function automatic logic [R1W-1:0] l1_fill(input logic [R1W-1:0] row,
                                               input logic [T1W-1:0] t);
        logic [R1W-1:0] r;
        logic           inv;
        logic           lru;
        logic [W1B-1:0] w;
        inv = 1'b0;
        lru = 1'b0;
        w   = '0;
        for (int v = 0; v < L1_ASSOC; v++)
        begin
            if (!inv && !row[v*E1W])
            begin
                inv = 1'b1;
                w   = W1B'(v);
            end
        end
        if (!inv)
        begin
            for (int v = 0; v < L1_ASSOC; v++)
            begin
                if (!lru && row[v*E1W+1 +: RW] == RW'(L1_ASSOC - 1))
                begin
                    lru = 1'b1;
                    w   = W1B'(v);
                end
            end
        end
        r = l1_touch(row, w);
        for (int v = 0; v < L1_ASSOC; v++)
        begin
            if (W1B'(v) == w)
            begin
                r[v*E1W]              = 1'b1;
                r[v*E1W+1+RW +: T1W]  = t;
            end
        end
        return r;
    endfunction

    // Update an L2 set on a hit or a fill
    function automatic logic [R2W-1:0] l2_update(input logic [R2W-1:0] row,
                                                 input logic hit,
                                                 input logic aging,
                                                 input logic [1:0] inc,
                                                 input logic [W2B-1:0] w,
                                                 input logic [T2W-1:0] t);
        logic [R2W-1:0] r;
        r = row;
        for (int v = 0; v < L2_ASSOC; v++)
        begin
            if (hit)
            begin
                if (W2B'(v) == w)
                begin
                    r[v*E2W+1 +: 2] = 2'd0;
                end
            end
            else
            begin
                if (aging && row[v*E2W])
                begin
                    r[v*E2W+1 +: 2] = row[v*E2W+1 +: 2] + inc;
                end
                if (W2B'(v) == w)
                begin
                    r[v*E2W]           = 1'b1;
                    r[v*E2W+1 +: 2]    = RRPV_INSERT;
                    r[v*E2W+3 +: T2W]  = t;
                end
            end
        end
        return r;
    endfunction

    // Compare ways of both sets and find the L2 victim
    always_comb
    begin
        logic has3;
        logic has2;
        logic has1;
        logic agefound;
        hit1     = 1'b0;
        hitw1    = '0;
        hit2     = 1'b0;
        hitw2    = '0;
        inv_any  = 1'b0;
        invw2    = '0;
        has3     = 1'b0;
        has2     = 1'b0;
        has1     = 1'b0;
        agefound = 1'b0;
        agew2    = '0;
        agetag   = '0;
        for (int v = 0; v < L1_ASSOC; v++)
        begin
            if (!hit1 && rd1[v*E1W] && rd1[v*E1W+1+RW +: T1W] == tag1)
            begin
                hit1  = 1'b1;
                hitw1 = W1B'(v);
            end
        end
        for (int v = 0; v < L2_ASSOC; v++)
        begin
            if (!hit2 && rd2[v*E2W] && rd2[v*E2W+3 +: T2W] == tag2)
            begin
                hit2  = 1'b1;
                hitw2 = W2B'(v);
            end
            if (!inv_any && !rd2[v*E2W])
            begin
                inv_any = 1'b1;
                invw2   = W2B'(v);
            end
            has3 = has3 | (rd2[v*E2W+1 +: 2] == 2'd3);
            has2 = has2 | rd2[v*E2W+2];
            has1 = has1 | (rd2[v*E2W+1 +: 2] != 2'd0);
        end
        maxage = has3 ? 2'd3 : (has2 ? 2'd2 : (has1 ? 2'd1 : 2'd0));
        for (int v = 0; v < L2_ASSOC; v++)
        begin
            if (!agefound && rd2[v*E2W+1 +: 2] == maxage)
            begin
                agefound = 1'b1;
                agew2    = W2B'(v);
                agetag   = rd2[v*E2W+3 +: T2W];
            end
        end
    end

    // Datapath, memory ports and register next values
    always_comb
    begin
        re1        = 1'b0;
        we1        = 1'b0;
        raddr1     = set1;
        waddr1     = set1;
        wdata1     = rd1;
        re2        = 1'b0;
        we2        = 1'b0;
        raddr2     = set2;
        waddr2     = set2;
        wdata2     = rd2;
        pop        = 1'b0;
        out_load   = 1'b0;
        clr_next   = clr_reg;
        line_next  = line_reg;
        last_next  = last_reg;
        l1h_next   = l1h_reg;
        l2h_next   = l2h_reg;
        vv_next    = vv_reg;
        vline_next = vline_reg;
        way1_next  = way1_reg;
        pick2_next = pick2_reg;
        inc_next   = inc_reg;
        l1cnt_next = l1cnt_reg;
        l2cnt_next = l2cnt_reg;

        unique case (state_reg)
            BK_CLEAR:
            begin
                we1      = ({1'b0, clr_reg} < (CW+1)'(L1_SETS));
                waddr1   = clr_reg[S1B-1:0];
                wdata1   = '0;
                we2      = ({1'b0, clr_reg} < (CW+1)'(L2_SETS));
                waddr2   = clr_reg[S2B-1:0];
                wdata2   = '0;
                clr_next = clr_reg + CW'(1);
            end
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    pop       = 1'b1;
                    re1       = 1'b1;
                    re2       = 1'b1;
                    raddr1    = pop_item.line[S1B-1:0];
                    raddr2    = pop_item.line[S2B-1:0];
                    line_next = pop_item.line;
                    last_next = pop_item.last;
                end
            end
            BK_LOOK:
            begin
                l1h_next   = hit1;
                way1_next  = hitw1;
                l2h_next   = !hit1 && hit2;
                vv_next    = !hit1 && !hit2 && !inv_any;
                vline_next = (!hit1 && !hit2 && !inv_any) ? {agetag, set2} : '0;
                pick2_next = hit2 ? hitw2 : (inv_any ? invw2 : agew2);
                inc_next   = RRPV_MAX - maxage;
                if (!hit1)
                begin
                    l1cnt_next = l1cnt_reg + CNT_W'(1);
                    if (!hit2)
                    begin
                        l2cnt_next = l2cnt_reg + CNT_W'(1);
                    end
                end
            end
            BK_L1WR:
            begin
                we1    = 1'b1;
                wdata1 = l1_touch(rd1, way1_reg);
            end
            BK_L2WR:
            begin
                we2    = 1'b1;
                wdata2 = l2_update(rd2, l2h_reg, vv_reg, inc_reg, pick2_reg, tag2);
                re1    = 1'b1;
                raddr1 = vv_reg ? vline_reg[S1B-1:0] : set1;
            end
            BK_BWR:
            begin
                we1    = 1'b1;
                waddr1 = vline_reg[S1B-1:0];
                wdata1 = l1_inval(rd1, vline_reg[LINE_W-1:S1B]);
            end
            BK_FRD:
            begin
                re1 = 1'b1;
            end
            BK_FWR:
            begin
                we1    = 1'b1;
                wdata1 = l1_fill(rd1, tag1);
            end
            BK_OUT:
            begin
                out_load = !out_valid_reg || !result_stall;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Lookup; L1 hit: L1 update; else L2 update, victim back-inval, L1 fill
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR: if (clr_last) state_next = BK_IDLE;
            BK_IDLE:  if (pop_valid) state_next = BK_LOOK;
            BK_LOOK:  state_next = hit1 ? BK_L1WR : BK_L2WR;
            BK_L1WR:  state_next = BK_OUT;
            BK_L2WR:  state_next = vv_reg ? BK_BWR : BK_FWR;
            BK_BWR:   state_next = BK_FRD;
            BK_FRD:   state_next = BK_FWR;
            BK_FWR:   state_next = BK_OUT;
            BK_OUT:   if (out_load) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // Hold the result until the transfer
    always_comb
    begin
        out_valid_next = out_load || (out_valid_reg && result_stall);
        out_next       = out_reg;
        if (out_load)
        begin
            out_next.line_number   = line_reg;
            out_next.l1_hit        = l1h_reg;
            out_next.l2_hit        = l2h_reg;
            out_next.victim_valid  = vv_reg;
            out_next.victim_line   = vline_reg;
            out_next.l1_miss_total = l1cnt_reg;
            out_next.l2_miss_total = l2cnt_reg;
            out_next.last_line     = last_reg;
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_reg       <= '0;
            l1cnt_reg     <= '0;
            l2cnt_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            l1cnt_reg     <= l1cnt_next;
            l2cnt_reg     <= l2cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg  <= line_next;
        last_reg  <= last_next;
        l1h_reg   <= l1h_next;
        l2h_reg   <= l2h_next;
        vv_reg    <= vv_next;
        vline_reg <= vline_next;
        way1_reg  <= way1_next;
        pick2_reg <= pick2_next;
        inc_reg   <= inc_next;
        out_reg   <= out_next;
    end

endmodule

>>> design/two_level_inclusive_srrip_cache.sv
// Channel   Direction  Payload     Handshake
// access    in         access_t    access_valid / access_stall
// result    out        result_t    result_valid / result_stall
//
// Each access splits into up to nine lines; each line gives one result.
// On an L1 hit a line steps through IDLE, LOOK, L1WR and OUT; on a miss through
// IDLE, LOOK, L2WR, BWR and FRD (with an L2 victim only), FWR and OUT.
// After reset a clearing pass over max(L1_SETS, L2_SETS) set addresses runs first.
// A stalled result waits in the output register; the front queues until full.
module two_level_inclusive_srrip_cache #(
    parameter int L1_SETS  = tlic_pkg::L1_SETS_DEF,
    parameter int L1_ASSOC = tlic_pkg::L1_ASSOC_DEF,
    parameter int L2_SETS  = tlic_pkg::L2_SETS_DEF,
    parameter int L2_ASSOC = tlic_pkg::L2_ASSOC_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tlic_pkg::access_t access,
    input  logic              access_valid,
    output logic              access_stall,
    output tlic_pkg::result_t result,
    output logic              result_valid,
    input  logic              result_stall
);
    import tlic_pkg::*;

    line_item_t push_item;
    line_item_t pop_item;
    logic       push_valid;
    logic       full;
    logic       pop_valid;
    logic       pop;

    tlic_front u_front (
        .clk(clk), .rst_n(rst_n),
        .access(access), .access_valid(access_valid), .access_stall(access_stall),
        .item(push_item), .item_valid(push_valid), .item_full(full)
    );

    tlic_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_item(push_item), .push_valid(push_valid), .full(full),
        .pop_item(pop_item), .pop_valid(pop_valid), .pop(pop)
    );

    tlic_back #(
        .L1_SETS(L1_SETS), .L1_ASSOC(L1_ASSOC),
        .L2_SETS(L2_SETS), .L2_ASSOC(L2_ASSOC)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .pop_item(pop_item), .pop_valid(pop_valid), .pop(pop),
        .result(result), .result_valid(result_valid), .result_stall(result_stall)
    );

endmodule
